### rtl/wtsm_pkg.sv
// Package for the whole-token substring matcher.
// Holds the configuration defaults, register indexes, cell status type and
// the character class functions; depends on nothing.
`default_nettype none
package wtsm_pkg;

  localparam int NeedleMaxDefault = 8;
  localparam int CharBitsDefault  = 16;
  localparam int PortCharBits     = 16;

  typedef enum logic [1:0] {
    REG_CHARS_LO = 2'd0,
    REG_CHARS_HI = 2'd1,
    REG_LENGTH   = 2'd2,
    REG_NONE     = 2'd3
  } wtsm_reg_e;

  typedef struct packed {
    logic eq_cur;
    logic eq_nxt;
    logic left_ok;
  } wtsm_cell_stat_t;

  function automatic logic [15:0] fold(input logic [15:0] c);
    logic [15:0] r;
    r = c;
    if (c >= 16'h0041 && c <= 16'h005A) begin
      r = c + 16'd32;
    end
    return r;
  endfunction

  function automatic logic left_ok(input logic [15:0] c);
    return c == 16'h0020 || c == 16'h005C || c == 16'h002F || c == 16'h0022 ||
           c == 16'h0027 || c == 16'h003D || c == 16'h003A;
  endfunction

  function automatic logic right_ok(input logic [15:0] c);
    return c == 16'h0020 || c == 16'h005C || c == 16'h002F || c == 16'h0022 ||
           c == 16'h0027 || c == 16'h002E || c == 16'h002D || c == 16'h002C;
  endfunction

  function automatic logic [15:0] needle_char(input logic [63:0] lo,
                                              input logic [63:0] hi,
                                              input logic [4:0]  j);
    logic [127:0] both;
    logic [15:0]  r;
    both = {hi, lo};
    r    = 16'd0;
    if (j < 5'd8) begin
      r = both[{j[2:0], 4'b0000} +: 16];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/whole_token_substring_matcher.sv
// Top level of the whole-token substring matcher: APB registers, a chain of wtsm_cell
// window cells, the match decision and a two-entry result buffer; uses wtsm_pkg.
// The result is registered into the output slot, or into the second slot while the output slot is full.
// Throughput: one character per cycle while the input is not stalled; the compare across the cells is combinational.
// Input is stalled only while both result slots are full.
// Reset clears the window, count, flag and result slots, zeroes the needle and sets length 1.
`default_nettype none
module whole_token_substring_matcher
  import wtsm_pkg::*;
#(
  parameter int NEEDLE_MAX = NeedleMaxDefault,
  parameter int CHAR_BITS  = CharBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] char_code_i,
  input  wire logic        last_char_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             found_o
);

  localparam int CW = (CHAR_BITS < PortCharBits) ? CHAR_BITS : PortCharBits;
  localparam int W  = NEEDLE_MAX + 1;
  localparam int NW = $clog2(NEEDLE_MAX + 1);
  localparam int SW = $clog2(W + 1);

  logic [63:0] chars_lo_q, chars_hi_q;
  logic [3:0]  length_q;
  wtsm_reg_e   reg_sel;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_sel = wtsm_reg_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_CHARS_LO: prdata = chars_lo_q;
      REG_CHARS_HI: prdata = chars_hi_q;
      REG_LENGTH:   prdata = {60'd0, length_q};
      default:      prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_lo_q <= 64'd0;
      chars_hi_q <= 64'd0;
      length_q   <= 4'd1;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CHARS_LO: chars_lo_q <= pwdata;
        REG_CHARS_HI: chars_hi_q <= pwdata;
        REG_LENGTH:   length_q   <= pwdata[3:0];
        default:      ;
      endcase
    end
  end

  logic [NW-1:0] n_len;
  always_comb begin
    if (length_q == 4'd0) begin
      n_len = NW'(1);
    end else if ({1'b0, length_q} > 5'(NEEDLE_MAX)) begin
      n_len = NW'(NEEDLE_MAX);
    end else begin
      n_len = NW'(length_q);
    end
  end

  logic            accept, last_acc;
  logic [CW-1:0]   c_in;
  logic [CW-1:0]   chain [W+1];
  wtsm_cell_stat_t stat [W];
  logic [W-1:0]    eq_cur_ok, eq_nxt_ok, lok;

  assign accept   = in_valid_i && !in_stall_o;
  assign last_acc = accept && last_char_i;
  assign c_in     = char_code_i[CW-1:0];
  assign chain[0] = c_in;

  for (genvar m = 0; m < W; m++) begin : g_cell
    logic [NW-1:0] idx_cur, idx_nxt;
    logic [CW-1:0] nd_cur, nd_nxt;
    assign idx_cur = NW'(n_len - NW'(1) - NW'(m));
    assign idx_nxt = NW'(n_len - NW'(2) - NW'(m));
    assign nd_cur  = CW'(needle_char(chars_lo_q, chars_hi_q, 5'(idx_cur)));
    assign nd_nxt  = CW'(needle_char(chars_lo_q, chars_hi_q, 5'(idx_nxt)));

    wtsm_cell #(
      .CW(CW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (accept),
      .clear_i      (last_char_i),
      .char_i       (chain[m]),
      .needle_cur_i (nd_cur),
      .needle_nxt_i (nd_nxt),
      .char_o       (chain[m+1]),
      .stat_o       (stat[m])
    );

    assign eq_cur_ok[m] = stat[m].eq_cur || (NW'(m) >= n_len);
    assign eq_nxt_ok[m] = stat[m].eq_nxt || ((NW'(m) + NW'(1)) >= n_len);
    assign lok[m]       = stat[m].left_ok;
  end

  logic [SW-1:0] seen_q, seen_d, seen_inc;
  logic          found_q, found_d;
  logic          match_cur, match_nxt, head_eq, found_acc, result;
  logic [SW-1:0] n_ext;
  logic [CW-1:0] nd_head;

  assign n_ext    = SW'(n_len);
  assign seen_inc = (seen_q == SW'(W)) ? seen_q : SW'(seen_q + SW'(1));
  assign nd_head  = CW'(needle_char(chars_lo_q, chars_hi_q, 5'(NW'(n_len - NW'(1)))));
  assign head_eq  = fold(16'(c_in)) == fold(16'(nd_head));

  assign match_cur = (seen_q >= n_ext) && (&eq_cur_ok) &&
                     ((seen_q == n_ext) || lok[n_len]);
  assign match_nxt = (seen_inc >= n_ext) && head_eq && (&eq_nxt_ok) &&
                     ((seen_inc == n_ext) || lok[NW'(n_len - NW'(1))]);

  assign found_acc = found_q || (right_ok(16'(c_in)) && match_cur);
  assign result    = found_acc || match_nxt;

  always_comb begin
    seen_d  = seen_q;
    found_d = found_q;
    if (accept) begin
      if (last_char_i) begin
        seen_d  = '0;
        found_d = 1'b0;
      end else begin
        seen_d  = seen_inc;
        found_d = found_acc;
      end
    end
  end

  logic out_valid_q, out_valid_d, out_found_q, out_found_d;
  logic skid_valid_q, skid_valid_d, skid_found_q, skid_found_d;
  logic pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    skid_valid_d = skid_valid_q;
    skid_found_d = skid_found_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_found_d  = skid_found_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = last_acc;
        out_found_d = result;
      end
    end else if (last_acc) begin
      if (out_valid_q) begin
        skid_valid_d = 1'b1;
        skid_found_d = result;
      end else begin
        out_valid_d = 1'b1;
        out_found_d = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= '0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      seen_q       <= seen_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q  <= out_found_d;
    skid_found_q <= skid_found_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Result skid slot is full while the output slot is empty.");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SW'(W))
    else $error("Character count exceeds the window depth.");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> (seen_q == '0) && !found_q)
    else $error("String state not cleared after the last character.");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(last_acc))
    else $error("Result transaction appeared without a last character.");

endmodule
`default_nettype wire

### rtl/wtsm_cell.sv
// One window cell of the whole-token substring matcher.
// Holds one stored character, passes it to the next cell on every transaction
// and compares it against two needle alignments; uses wtsm_pkg.
`default_nettype none
module wtsm_cell
  import wtsm_pkg::*;
#(
  parameter int CW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire logic          clear_i,
  input  wire logic [CW-1:0] char_i,
  input  wire logic [CW-1:0] needle_cur_i,
  input  wire logic [CW-1:0] needle_nxt_i,
  output logic [CW-1:0]      char_o,
  output wtsm_cell_stat_t    stat_o
);

  logic [CW-1:0] char_q, char_d;

  always_comb begin
    char_d = char_q;
    if (shift_i) begin
      char_d = clear_i ? '0 : char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  assign char_o         = char_q;
  assign stat_o.eq_cur  = fold(16'(char_q)) == fold(16'(needle_cur_i));
  assign stat_o.eq_nxt  = fold(16'(char_q)) == fold(16'(needle_nxt_i));
  assign stat_o.left_ok = left_ok(16'(char_q));

endmodule
`default_nettype wire
